### src/ierq_pkg.sv
`timescale 1ns / 1ps
// Package for the input event replay queue.
// It holds the queue sizes, the request kind codes and the event and queue control types.
// It has no dependencies.
package ierq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int MASK_W = 64;
   localparam int COORD_W = 16;
   localparam int FRAMES_W = 16;

   typedef enum logic [1:0] {
      KIND_PRESS = 2'd0,
      KIND_TOUCH = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef struct packed {
      logic                is_touch;
      logic [MASK_W-1:0]   buttons;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [FRAMES_W-1:0] frames;
   } event_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### src/ierq_queue.sv
`timescale 1ns / 1ps
// Circular event queue with head, tail and fill count.
// Depends on ierq_pkg for the depth, the event type and the control types.
module ierq_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  ierq_pkg::queue_ctrl_type    ctrl,
   input  ierq_pkg::event_type         push_event,
   output ierq_pkg::event_type         head_event,
   output ierq_pkg::queue_status_type  status
);

   ierq_pkg::event_type             entries_ff [ierq_pkg::QUEUE_DEPTH];
   logic [ierq_pkg::IDX_W-1:0]      head_ff;
   logic [ierq_pkg::IDX_W-1:0]      head_in;
   logic [ierq_pkg::IDX_W-1:0]      tail_ff;
   logic [ierq_pkg::IDX_W-1:0]      tail_in;
   logic [ierq_pkg::CNT_W-1:0]      count_ff;
   logic [ierq_pkg::CNT_W-1:0]      count_in;
   logic                            do_push;
   logic                            do_pop;

   localparam logic [ierq_pkg::IDX_W-1:0] LAST_IDX = ierq_pkg::IDX_W'(ierq_pkg::QUEUE_DEPTH - 1);
   localparam logic [ierq_pkg::CNT_W-1:0] FULL_CNT = ierq_pkg::CNT_W'(ierq_pkg::QUEUE_DEPTH);

   always_comb begin
      status.full  = (count_ff == FULL_CNT);
      status.empty = (count_ff == '0);
      do_push = ctrl.push && !status.full;
      do_pop  = ctrl.pop && !status.empty;
      head_event = entries_ff[head_ff];

      head_in = head_ff;
      if (do_pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      end
      tail_in = tail_ff;
      if (do_push) begin
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[tail_ff] <= push_event;
      end
   end

endmodule

### src/input_event_replay_queue_top.sv
`timescale 1ns / 1ps
// Top level of the input event replay queue: request register, event logic, response register.
// Depends on ierq_pkg and ierq_queue.
//
// The block takes one request per clock cycle unless a response is stalled, and returns exactly one
// response for each request. A request is first captured in an input register; once the response
// register is free, the queue access, the active event update and the response value are formed in
// one pass and written to the response register, from which the response is driven. While a
// response waits for the response side, a request in the input register is held there and no
// further request is taken; a new request is taken in the same cycle as the waiting response leaves.
// Enqueue requests return a zero response that only carries the dropped flag, and frame ticks return
// the masks or the touch of the active event. The queue holds sixteen events.
module input_event_replay_queue_top (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // tdata: button_mask[63:0], touch_x[79:64], touch_y[95:80], frame_count[111:96]
   input  logic [111:0]   req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]     req_tuser,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // tdata: down_mask[63:0], held_mask[127:64], reported_x[143:128], reported_y[159:144]
   output logic [159:0]   rsp_tdata,
   // tuser: touch_active[0], dropped[1]
   output logic [1:0]     rsp_tuser
);

   localparam int MW = ierq_pkg::MASK_W;
   localparam int CW = ierq_pkg::COORD_W;
   localparam int FW = ierq_pkg::FRAMES_W;

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [1:0]      in_kind_ff;
   logic [MW-1:0]   in_mask_ff;
   logic [CW-1:0]   in_x_ff;
   logic [CW-1:0]   in_y_ff;
   logic [FW-1:0]   in_frames_ff;

   logic            advance;
   logic            process;

   logic            active_flag_ff;
   logic            active_flag_in;
   logic            active_kind_ff;
   logic            active_kind_in;
   logic [MW-1:0]   active_buttons_ff;
   logic [MW-1:0]   active_buttons_in;
   logic [CW-1:0]   active_x_ff;
   logic [CW-1:0]   active_x_in;
   logic [CW-1:0]   active_y_ff;
   logic [CW-1:0]   active_y_in;
   logic [FW-1:0]   active_hold_ff;
   logic [FW-1:0]   active_hold_in;
   logic [FW-1:0]   frames_left_ff;
   logic [FW-1:0]   frames_left_in;
   logic [FW-1:0]   frames_eff;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [MW-1:0]   down_ff;
   logic [MW-1:0]   down_in;
   logic [MW-1:0]   held_ff;
   logic [MW-1:0]   held_in;
   logic [CW-1:0]   rx_ff;
   logic [CW-1:0]   rx_in;
   logic [CW-1:0]   ry_ff;
   logic [CW-1:0]   ry_in;
   logic            touch_ff;
   logic            touch_in;
   logic            dropped_ff;
   logic            dropped_in;

   ierq_pkg::queue_ctrl_type    q_ctrl;
   ierq_pkg::queue_status_type  q_status;
   ierq_pkg::event_type         q_push;
   ierq_pkg::event_type         q_head;

   ierq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (q_ctrl),
      .push_event (q_push),
      .head_event (q_head),
      .status     (q_status)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign process    = in_valid_ff && advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   assign frames_eff = (in_frames_ff == '0) ? FW'(1) : in_frames_ff;

   always_comb begin
      q_ctrl = '0;
      q_push.is_touch = 1'b0;
      q_push.buttons  = in_mask_ff;
      q_push.x        = '0;
      q_push.y        = '0;
      q_push.frames   = frames_eff;

      active_flag_in    = active_flag_ff;
      active_kind_in    = active_kind_ff;
      active_buttons_in = active_buttons_ff;
      active_x_in       = active_x_ff;
      active_y_in       = active_y_ff;
      active_hold_in    = active_hold_ff;
      frames_left_in    = frames_left_ff;

      down_in    = '0;
      held_in    = '0;
      rx_in      = '0;
      ry_in      = '0;
      touch_in   = 1'b0;
      dropped_in = 1'b0;

      case (in_kind_ff)
         ierq_pkg::KIND_PRESS: begin
            q_ctrl.push = process;
            dropped_in  = q_status.full;
         end
         ierq_pkg::KIND_TOUCH: begin
            q_ctrl.push     = process;
            q_push.is_touch = 1'b1;
            q_push.buttons  = '0;
            q_push.x        = in_x_ff;
            q_push.y        = in_y_ff;
            dropped_in      = q_status.full;
         end
         ierq_pkg::KIND_TICK: begin
            if (!active_flag_ff && !q_status.empty) begin
               q_ctrl.pop        = process;
               active_flag_in    = 1'b1;
               active_kind_in    = q_head.is_touch;
               active_buttons_in = q_head.buttons;
               active_x_in       = q_head.x;
               active_y_in       = q_head.y;
               active_hold_in    = q_head.frames;
               frames_left_in    = q_head.frames;
            end
            if (active_flag_in) begin
               if (!active_kind_in) begin
                  down_in = (frames_left_in == active_hold_in) ? active_buttons_in : '0;
                  held_in = active_buttons_in;
               end else begin
                  touch_in = 1'b1;
                  rx_in    = active_x_in;
                  ry_in    = active_y_in;
               end
               if (frames_left_in != '0) begin
                  frames_left_in = frames_left_in - 1'b1;
               end
               if (frames_left_in == '0) begin
                  active_flag_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         active_flag_ff    <= 1'b0;
         active_kind_ff    <= 1'b0;
         active_buttons_ff <= '0;
         active_x_ff       <= '0;
         active_y_ff       <= '0;
         active_hold_ff    <= '0;
         frames_left_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            active_flag_ff    <= active_flag_in;
            active_kind_ff    <= active_kind_in;
            active_buttons_ff <= active_buttons_in;
            active_x_ff       <= active_x_in;
            active_y_ff       <= active_y_in;
            active_hold_ff    <= active_hold_in;
            frames_left_ff    <= frames_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff   <= req_tuser;
         in_mask_ff   <= req_tdata[63:0];
         in_x_ff      <= req_tdata[79:64];
         in_y_ff      <= req_tdata[95:80];
         in_frames_ff <= req_tdata[111:96];
      end
      if (process) begin
         down_ff    <= down_in;
         held_ff    <= held_in;
         rx_ff      <= rx_in;
         ry_ff      <= ry_in;
         touch_ff   <= touch_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ry_ff, rx_ff, held_ff, down_ff};
   assign rsp_tuser  = {dropped_ff, touch_ff};

endmodule

### src/ierq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the input event replay queue, bound to the top level.
// It sees only the top-level response ports and has no package dependency.
module ierq_checker (
   input logic           clock,
   input logic           reset,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [159:0]   rsp_tdata,
   input logic [1:0]     rsp_tuser
);

   // A stalled response keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // A refused enqueue reports nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("dropped response carries event data");

   // A touch frame carries no button masks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[127:0] == '0)
      else $error("touch response carries button masks");

   // Newly pressed buttons are always among the held buttons.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:0] & ~rsp_tdata[127:64]) == '0)
      else $error("down mask not covered by held mask");

   // Coordinates are reported only with the touch flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[159:128] == '0)
      else $error("coordinates without touch flag");

endmodule

bind input_event_replay_queue_top ierq_checker u_ierq_checker (.*);
